>>> hw/rtl/ecsm_pkg.sv
// Shared types, constants and helpers for the elliptic-curve scalar multiply core.
`default_nettype none
package ecsm_pkg;

    localparam int FIELD_BITS = 16;
    localparam int DIV_NUM_W  = 2 * FIELD_BITS;
    localparam int COEF_W     = FIELD_BITS + 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 1'b1;

    localparam logic [FIELD_BITS-1:0] PRIME_RESET   = FIELD_BITS'(23);
    localparam logic [FIELD_BITS-1:0] CURVE_A_RESET = FIELD_BITS'(1);

    typedef logic [FIELD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord base_x;
        t_coord base_y;
        logic [15:0] scalar_k;
    } t_in_word;

    typedef struct packed {
        t_coord result_x;
        t_coord result_y;
        logic   hit_negative;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RED_GX,
        OP_RED_GY,
        OP_RED_A,
        OP_GXSQ,
        OP_SNUM_D,
        OP_DEN_D,
        OP_SNUM_A,
        OP_DEN_A,
        OP_EUC,
        OP_FIN,
        OP_SLOPE,
        OP_NX,
        OP_NY
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIV,
        PH_POST,
        PH_WB
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_GX,
        S_RED_GY,
        S_RED_A,
        S_CHECK,
        S_GXSQ,
        S_SNUM_D,
        S_DEN_D,
        S_SNUM_A,
        S_DEN_A,
        S_EUC_CHK,
        S_EUC,
        S_FIN,
        S_SLOPE,
        S_NX,
        S_NY,
        S_STEP,
        S_EMIT
    } t_ctrl_state;

    typedef struct packed {
        logic go;
        t_op  op;
        logic load;
        logic inc;
        logic emit;
        logic emit_hit;
    } t_dp_cmd;

    typedef struct packed {
        logic op_done;
        logic p_small;
        logic k_small;
        logic at_neg;
        logic at_base;
        logic euc_go;
        logic order_eq_k;
        logic out_free;
    } t_dp_status;

    // (u - v) mod p for u, v already below p
    function automatic t_coord sub_mod(input t_coord u, input t_coord v, input t_coord p);
        logic [FIELD_BITS:0] sum;
        begin
            if (u >= v) begin
                sum = {1'b0, u} - {1'b0, v};
            end else begin
                sum = {1'b0, u} + {1'b0, p} - {1'b0, v};
            end
            sub_mod = sum[FIELD_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ecsm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ecsm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ecsm_pkg::DIV_NUM_W-1:0]  i_num,
    input  wire logic [ecsm_pkg::FIELD_BITS-1:0] i_den,
    output logic                              o_done,
    output logic [ecsm_pkg::DIV_NUM_W-1:0]    o_quo,
    output logic [ecsm_pkg::FIELD_BITS-1:0]   o_rem
);
    import ecsm_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [FIELD_BITS-1:0] r_rem;

    logic [FIELD_BITS:0]   trial;
    logic [FIELD_BITS:0]   diff;
    logic                  ge;
    logic [FIELD_BITS-1:0] n_rem;

    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};
    assign n_rem = ge ? diff[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

>>> hw/rtl/ecsm_dp.sv
// Datapath: point registers, Euclid coefficients, shared multiplier and divider.
`default_nettype none
module ecsm_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ecsm_pkg::t_dp_cmd     i_cmd,
    input  wire ecsm_pkg::t_in_word    i_in_word,
    input  wire ecsm_pkg::t_coord      i_prime,
    input  wire ecsm_pkg::t_coord      i_curve_a,
    input  wire logic                  i_out_ready,
    output ecsm_pkg::t_dp_status       o_status,
    output logic                       o_out_valid,
    output ecsm_pkg::t_out_word        o_out_word
);
    import ecsm_pkg::*;

    t_phase r_phase;
    t_phase n_phase;

    t_coord r_gx, r_gy, r_nx, r_ny, r_a, r_s, r_t, r_u, r_m;
    logic [15:0] r_k, r_order;
    logic signed [COEF_W-1:0] r_cx, r_cy, r_qcy;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic                  div_start;
    logic                  div_done;
    logic [DIV_NUM_W-1:0]  div_num;
    t_coord                div_den;
    logic [DIV_NUM_W-1:0]  div_quo;
    t_coord                div_rem;

    t_coord                mul_a, mul_b;
    logic [DIV_NUM_W-1:0]  prod;
    logic [COEF_W-1:0]     cx_mag;
    logic [FIELD_BITS:0]   twice_gy;
    logic [FIELD_BITS:0]   neg_ny;
    logic signed [COEF_W+FIELD_BITS:0] qcy_full;
    logic                  op_done;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (i_cmd.go) n_phase = PH_DIV;
            PH_DIV:  if (div_done) n_phase = PH_POST;
            PH_POST: n_phase = PH_WB;
            PH_WB:   n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    // phase outputs
    always_comb begin
        div_start = 1'b0;
        op_done   = 1'b0;
        case (r_phase)
            PH_IDLE: div_start = i_cmd.go;
            PH_WB:   op_done   = 1'b1;
            default: begin
                div_start = 1'b0;
                op_done   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign cx_mag = r_cx[COEF_W-1] ? COEF_W'(-r_cx) : COEF_W'(r_cx);

    // shared multiplier operand select
    always_comb begin
        mul_a = r_s;
        mul_b = r_s;
        case (i_cmd.op)
            OP_GXSQ:  begin mul_a = r_gx; mul_b = r_gx; end
            OP_SNUM_D: begin mul_a = r_t; mul_b = FIELD_BITS'(3); end
            OP_SLOPE: begin mul_a = r_s; mul_b = r_t; end
            OP_NY:    begin mul_a = r_s; mul_b = sub_mod(r_gx, r_nx, i_prime); end
            default:  begin mul_a = r_s; mul_b = r_s; end
        endcase
    end

    assign prod = DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b);

    always_comb begin
        div_den = i_prime;
        case (i_cmd.op)
            OP_RED_GX: div_num = DIV_NUM_W'(r_gx);
            OP_RED_GY: div_num = DIV_NUM_W'(r_gy);
            OP_RED_A:  div_num = DIV_NUM_W'(r_a);
            OP_SNUM_D: div_num = prod + DIV_NUM_W'(r_a);
            OP_EUC: begin
                div_num = DIV_NUM_W'(r_u);
                div_den = r_m;
            end
            OP_FIN:    div_num = DIV_NUM_W'(cx_mag);
            default:   div_num = prod;
        endcase
    end

    ecsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign twice_gy = {r_gy, 1'b0};
    assign neg_ny   = {1'b0, i_prime} - {1'b0, r_ny};
    assign qcy_full = $signed({1'b0, div_quo[FIELD_BITS-1:0]}) * r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx    <= i_in_word.base_x;
            r_gy    <= i_in_word.base_y;
            r_nx    <= i_in_word.base_x;
            r_ny    <= i_in_word.base_y;
            r_k     <= i_in_word.scalar_k;
            r_a     <= i_curve_a;
            r_order <= 16'd2;
        end
        if (i_cmd.inc) begin
            r_order <= r_order + 16'd1;
        end
        if (r_phase == PH_POST) begin
            r_qcy <= qcy_full[COEF_W-1:0];
        end
        if (r_phase == PH_WB) begin
            case (i_cmd.op)
                OP_RED_GX: r_gx <= div_rem;
                OP_RED_GY: r_gy <= div_rem;
                OP_RED_A: begin
                    r_a  <= div_rem;
                    r_nx <= r_gx;
                    r_ny <= r_gy;
                end
                OP_GXSQ:   r_t <= div_rem;
                OP_SNUM_D: r_s <= div_rem;
                OP_DEN_D: begin
                    r_u  <= (twice_gy >= {1'b0, i_prime})
                            ? FIELD_BITS'(twice_gy - {1'b0, i_prime})
                            : twice_gy[FIELD_BITS-1:0];
                    r_m  <= i_prime;
                    r_cx <= COEF_W'(1);
                    r_cy <= '0;
                end
                OP_SNUM_A: r_s <= sub_mod(r_ny, r_gy, i_prime);
                OP_DEN_A: begin
                    r_u  <= sub_mod(r_nx, r_gx, i_prime);
                    r_m  <= i_prime;
                    r_cx <= COEF_W'(1);
                    r_cy <= '0;
                end
                OP_EUC: begin
                    r_u  <= r_m;
                    r_m  <= div_rem;
                    r_cx <= r_cy;
                    r_cy <= r_cx - r_qcy;
                end
                OP_FIN: begin
                    r_t <= (r_cx[COEF_W-1] && div_rem != '0) ? (i_prime - div_rem) : div_rem;
                end
                OP_SLOPE: r_s <= div_rem;
                OP_NX: r_nx <= sub_mod(sub_mod(div_rem, r_gx, i_prime), r_nx, i_prime);
                OP_NY: r_ny <= sub_mod(div_rem, r_gy, i_prime);
                default: r_s <= r_s;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word.result_x     <= r_nx;
            r_out_word.result_y     <= r_ny;
            r_out_word.hit_negative <= i_cmd.emit_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        o_status.op_done    = op_done;
        o_status.p_small    = i_prime < FIELD_BITS'(3);
        o_status.k_small    = r_k < 16'd2;
        o_status.at_neg     = (r_nx == r_gx) && ({1'b0, r_gy} == neg_ny);
        o_status.at_base    = (r_nx == r_gx) && (r_ny == r_gy);
        o_status.euc_go     = (r_u > FIELD_BITS'(1)) && (r_m != '0);
        o_status.order_eq_k = r_order == r_k;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

endmodule
`default_nettype wire

>>> hw/rtl/ecsm_ctrl.sv
// Controller: sequences the reductions, slope, inversion and point update steps.
`default_nettype none
module ecsm_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ecsm_pkg::t_dp_status i_status,
    output ecsm_pkg::t_dp_cmd         o_cmd
);
    import ecsm_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_hit;
    logic        accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (accept) n_state = i_status.p_small ? S_EMIT : S_RED_GX;
            S_RED_GX:  if (i_status.op_done) n_state = S_RED_GY;
            S_RED_GY:  if (i_status.op_done) n_state = S_RED_A;
            S_RED_A:   if (i_status.op_done) n_state = i_status.k_small ? S_EMIT : S_CHECK;
            S_CHECK: begin
                if (i_status.at_neg) begin
                    n_state = S_EMIT;
                end else if (i_status.at_base) begin
                    n_state = S_GXSQ;
                end else begin
                    n_state = S_SNUM_A;
                end
            end
            S_GXSQ:    if (i_status.op_done) n_state = S_SNUM_D;
            S_SNUM_D:  if (i_status.op_done) n_state = S_DEN_D;
            S_DEN_D:   if (i_status.op_done) n_state = S_EUC_CHK;
            S_SNUM_A:  if (i_status.op_done) n_state = S_DEN_A;
            S_DEN_A:   if (i_status.op_done) n_state = S_EUC_CHK;
            S_EUC_CHK: n_state = i_status.euc_go ? S_EUC : S_FIN;
            S_EUC:     if (i_status.op_done) n_state = S_EUC_CHK;
            S_FIN:     if (i_status.op_done) n_state = S_SLOPE;
            S_SLOPE:   if (i_status.op_done) n_state = S_NX;
            S_NX:      if (i_status.op_done) n_state = S_NY;
            S_NY:      if (i_status.op_done) n_state = S_STEP;
            S_STEP:    n_state = i_status.order_eq_k ? S_EMIT : S_CHECK;
            S_EMIT:    if (i_status.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.emit_hit = r_hit;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = accept;
            end
            S_RED_GX: begin o_cmd.go = 1'b1; o_cmd.op = OP_RED_GX; end
            S_RED_GY: begin o_cmd.go = 1'b1; o_cmd.op = OP_RED_GY; end
            S_RED_A:  begin o_cmd.go = 1'b1; o_cmd.op = OP_RED_A;  end
            S_GXSQ:   begin o_cmd.go = 1'b1; o_cmd.op = OP_GXSQ;   end
            S_SNUM_D: begin o_cmd.go = 1'b1; o_cmd.op = OP_SNUM_D; end
            S_DEN_D:  begin o_cmd.go = 1'b1; o_cmd.op = OP_DEN_D;  end
            S_SNUM_A: begin o_cmd.go = 1'b1; o_cmd.op = OP_SNUM_A; end
            S_DEN_A:  begin o_cmd.go = 1'b1; o_cmd.op = OP_DEN_A;  end
            S_EUC:    begin o_cmd.go = 1'b1; o_cmd.op = OP_EUC;    end
            S_FIN:    begin o_cmd.go = 1'b1; o_cmd.op = OP_FIN;    end
            S_SLOPE:  begin o_cmd.go = 1'b1; o_cmd.op = OP_SLOPE;  end
            S_NX:     begin o_cmd.go = 1'b1; o_cmd.op = OP_NX;     end
            S_NY:     begin o_cmd.go = 1'b1; o_cmd.op = OP_NY;     end
            S_STEP:   o_cmd.inc  = !i_status.order_eq_k;
            S_EMIT:   o_cmd.emit = i_status.out_free;
            default:  o_cmd.op   = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_hit <= 1'b0;
            end else if (r_state == S_CHECK && i_status.at_neg) begin
                r_hit <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ec_scalar_multiply_small_field_core.sv
// Top level of the elliptic-curve scalar multiply core.
`default_nettype none
// Computes k*G on y^2 = x^3 + a*x + b over GF(p) by repeated affine point
// addition: the first step doubles G, every later step adds G, and the run
// ends when the step count reaches k or, earlier, when the running point
// equals -G (hit_negative set). k of 0 or 1 returns G; p below 3 returns the
// base point unreduced. One word is taken at a time; o_in_ready stays low
// until the result word has been loaded into the output register, which the
// next input word may then overtake. All arithmetic goes through one 32-step
// restoring divider, and each operation runs through start, the 32 divider
// steps, done, post and write-back in turn. There are three reductions up
// front, then per point step six to seven operations plus one per Euclid
// iteration of the slope inversion (at most about 24 for a 16-bit field),
// with a separate state for each Euclid test, for the -G check and for the
// step count. Configuration registers (index 0: prime p, index 1:
// coefficient a) must be written by the user only while the core is idle;
// the core itself does not enforce this.
module ec_scalar_multiply_small_field_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire ecsm_pkg::t_in_word                i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output ecsm_pkg::t_out_word                    o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [ecsm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ecsm_pkg::FIELD_BITS-1:0]   i_cfg_data
);
    import ecsm_pkg::*;

    t_coord     r_prime;
    t_coord     r_curve_a;
    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration registers; hold until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime   <= PRIME_RESET;
            r_curve_a <= CURVE_A_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PRIME:   r_prime   <= i_cfg_data;
                REG_CURVE_A: r_curve_a <= i_cfg_data;
                default:     r_prime   <= r_prime;
            endcase
        end
    end

    // sequencer: one operation at a time, advance on op_done
    ecsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and result register
    ecsm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_prime     (r_prime),
        .i_curve_a   (r_curve_a),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

>>> hw/rtl/ecsm_checker.sv
// Port-level checker for the scalar multiply core, bound to the top level.
`default_nettype none
module ecsm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire ecsm_pkg::t_in_word              i_in_word,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire ecsm_pkg::t_out_word             o_out_word
);
    import ecsm_pkg::*;

    // a result word waits unchanged until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one word at a time: ready drops once a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while busy");

    // a result appears only after the core has left idle
    a_no_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a word in progress");

endmodule

bind ec_scalar_multiply_small_field_core ecsm_checker u_ecsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
`default_nettype wire
